FILE: rtl/core/pds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLL divider search package
// Shared widths and constants of the pixel clock divider search.
// ----------------------------------------------------------------------------
package pds_pkg;

  // Field widths.
  localparam int CLK_W     = 20;  // requested pixel clock in kHz
  localparam int POST_W    = 6;   // post divider field
  localparam int LOOP_W    = 8;   // loop multiplier field
  localparam int REF_W     = 3;   // reference divider field
  localparam int B_W       = 22;  // VCO-side frequency in kHz, at most 3200000
  localparam int SCALE_W   = 14;  // holds 10000 plus the error limit
  localparam int ERR_W     = 6;   // holds the error limit

  // Search ranges and arithmetic constants.
  localparam int MAX_POST_DIV_DEF = 63;
  localparam int REF_KHZ          = 100000;
  localparam int SCALE            = 10000;
  localparam int ERR_LIMIT        = 50;
  localparam int REFDIV_HI        = 5;
  localparam int REFDIV_LO        = 3;
  localparam int LOOP_MIN_PER_REF = 12;
  localparam int LOOP_MAX_PER_REF = 32;

  // At the top of every reference divider sweep the loop multiplier is
  // 32 times the divider, so the VCO-side frequency is always the same.
  localparam int B_START = REF_KHZ * LOOP_MAX_PER_REF;

  // Per-step decrement of floor(100000 * L / R) when L drops by one.
  localparam int B_STEP_R5 = REF_KHZ / 5;
  localparam int B_STEP_R4 = REF_KHZ / 4;
  localparam int B_STEP_R3 = REF_KHZ / 3;

  // Loop multiplier bounds for a given reference divider.
  function automatic logic [LOOP_W-1:0] loop_lo(input logic [REF_W-1:0] r);
    return LOOP_W'(LOOP_MIN_PER_REF) * LOOP_W'(r);
  endfunction

  function automatic logic [LOOP_W-1:0] loop_hi(input logic [REF_W-1:0] r);
    return LOOP_W'(LOOP_MAX_PER_REF) * LOOP_W'(r);
  endfunction

endpackage

FILE: rtl/core/pll_divider_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLL divider search
// Finds post, reference and loop divider settings for a pixel clock.
// ----------------------------------------------------------------------------
// A word on the input channel is a requested pixel clock in kHz. The block
// walks every divider setting of a PLL fed by a 100 MHz reference, post
// divider from MAX_POST_DIV down to 1, reference divider 5 down to 3 and loop
// multiplier 32*R down to 12*R, and returns the first setting with the
// smallest error below 0.5 percent (found = 0 and all settings zero if none
// exists or the clock is zero). One candidate is scored per clock by a single
// shared multiply-and-compare unit, except that the scan holds for a short
// refinement after each improvement. A zero clock skips the scan and goes
// straight to the finish state. The block takes one word at a time; in_ready
// is high only while it is idle, but the result register lets a new word
// start while the previous result still waits on the output. A search that
// ends while an older result is still stalled waits until that result is
// taken.
//
// Scoring: with A = clock * P and B = floor(100000 * L / R), the error is
// floor(max * 10000 / min) - 10000. Instead of dividing, a candidate beats
// the best error E when max * 10000 < (10000 + E) * min. When it does, the
// exact new error is found by stepping E' down from E - 1 until
// (10000 + E') * min <= max * 10000, reusing the same multiplier. A and B are
// both kept incrementally: A drops by the clock when P steps, and B drops by
// 100000 / R (with a remainder tracked for R = 3) when L steps.
module pll_divider_search #(
  parameter int MAX_POST_DIV = pds_pkg::MAX_POST_DIV_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pds_pkg::CLK_W-1:0]    pixel_clock_khz,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         found,
  output logic [pds_pkg::POST_W-1:0]   post_divider,
  output logic [pds_pkg::LOOP_W-1:0]   loop_multiplier,
  output logic [pds_pkg::REF_W-1:0]    ref_divider
);
  import pds_pkg::*;

  localparam int PW    = $clog2(MAX_POST_DIV + 1);
  localparam int AW    = CLK_W + PW;
  localparam int CW    = (AW > B_W) ? AW : B_W;
  localparam int PRODW = CW + SCALE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REFINE,
    ST_FINISH
  } state_t;

  state_t state;

  // Candidate generator.
  logic [CLK_W-1:0]  clk_khz;
  logic [PW-1:0]     p;
  logic [REF_W-1:0]  r;
  logic [LOOP_W-1:0] l;
  logic [AW-1:0]     a;
  logic [B_W-1:0]    b;
  logic [1:0]        brem;
  logic              gen_done;

  // Scoring stage.
  logic              s1_valid;
  logic [PRODW-1:0]  s1_max10k;
  logic [CW-1:0]     s1_min;
  logic [PW-1:0]     s1_p;
  logic [LOOP_W-1:0] s1_l;
  logic [REF_W-1:0]  s1_r;

  // Best so far.
  logic [ERR_W-1:0]  best;
  logic [ERR_W-1:0]  k;
  logic              hit;
  logic [PW-1:0]     sel_p;
  logic [LOOP_W-1:0] sel_l;
  logic [REF_W-1:0]  sel_r;

  // Result register.
  logic              found_out;
  logic [PW-1:0]     sel_p_out;
  logic [LOOP_W-1:0] sel_l_out;
  logic [REF_W-1:0]  sel_r_out;

  // Combinational helpers.
  logic [CW-1:0]      a_ext;
  logic [CW-1:0]      b_ext;
  logic [CW-1:0]      cand_max;
  logic [CW-1:0]      cand_min;
  logic [PRODW-1:0]   cand_max10k;
  logic [ERR_W-1:0]   err_sel;
  logic [SCALE_W-1:0] factor;
  logic [PRODW-1:0]   prod;
  logic               beats_best;
  logic               refine_ok;
  logic               at_loop_lo;

  assign a_ext       = CW'(a);
  assign b_ext       = CW'(b);
  assign cand_max    = (a_ext > b_ext) ? a_ext : b_ext;
  assign cand_min    = (a_ext > b_ext) ? b_ext : a_ext;
  assign cand_max10k = PRODW'(cand_max) * PRODW'(SCALE);

  // Shared multiply-and-compare unit: the threshold is the current best
  // while scanning and the trial error while refining.
  assign err_sel    = (state == ST_REFINE) ? k : best;
  assign factor     = SCALE_W'(SCALE) + SCALE_W'(err_sel);
  assign prod       = PRODW'(s1_min) * PRODW'(factor);
  assign beats_best = s1_valid && (s1_max10k < prod);
  assign refine_ok  = (prod <= s1_max10k);
  assign at_loop_lo = (l == loop_lo(r));

  assign in_ready        = (state == ST_IDLE);
  assign post_divider    = POST_W'(sel_p_out);
  assign loop_multiplier = sel_l_out;
  assign ref_divider     = sel_r_out;
  assign found           = found_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      s1_valid  <= 1'b0;
      gen_done  <= 1'b0;
      hit       <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            clk_khz  <= pixel_clock_khz;
            a        <= AW'(pixel_clock_khz) * AW'(MAX_POST_DIV);
            p        <= PW'(MAX_POST_DIV);
            r        <= REF_W'(REFDIV_HI);
            l        <= loop_hi(REF_W'(REFDIV_HI));
            b        <= B_W'(B_START);
            brem     <= 2'd0;
            gen_done <= 1'b0;
            s1_valid <= 1'b0;
            best     <= ERR_W'(ERR_LIMIT);
            hit      <= 1'b0;
            sel_p    <= '0;
            sel_l    <= '0;
            sel_r    <= '0;
            state    <= (pixel_clock_khz == '0) ? ST_FINISH : ST_SCAN;
          end
        end

        ST_SCAN: begin
          if (beats_best) begin
            // Hold the generator and the scored candidate while refining.
            k     <= best - ERR_W'(1);
            state <= ST_REFINE;
          end else if (gen_done && !s1_valid) begin
            state <= ST_FINISH;
          end else begin
            s1_valid  <= !gen_done;
            s1_max10k <= cand_max10k;
            s1_min    <= cand_min;
            s1_p      <= p;
            s1_l      <= l;
            s1_r      <= r;
            if (!gen_done) begin
              if (at_loop_lo) begin
                b    <= B_W'(B_START);
                brem <= 2'd0;
                if (r == REF_W'(REFDIV_LO)) begin
                  if (p == PW'(1)) begin
                    gen_done <= 1'b1;
                  end else begin
                    p <= p - PW'(1);
                    a <= a - AW'(clk_khz);
                    r <= REF_W'(REFDIV_HI);
                    l <= loop_hi(REF_W'(REFDIV_HI));
                  end
                end else begin
                  r <= r - REF_W'(1);
                  l <= loop_hi(r - REF_W'(1));
                end
              end else begin
                l <= l - LOOP_W'(1);
                unique case (r)
                  REF_W'(5): b <= b - B_W'(B_STEP_R5);
                  REF_W'(4): b <= b - B_W'(B_STEP_R4);
                  REF_W'(3): begin
                    // 100000 = 3 * 33333 + 1, so the remainder wraps.
                    if (brem == 2'd0) begin
                      b    <= b - B_W'(B_STEP_R3 + 1);
                      brem <= 2'd2;
                    end else begin
                      b    <= b - B_W'(B_STEP_R3);
                      brem <= brem - 2'd1;
                    end
                  end
                  default: b <= b;
                endcase
              end
            end
          end
        end

        ST_REFINE: begin
          if (refine_ok) begin
            best     <= k;
            hit      <= 1'b1;
            sel_p    <= s1_p;
            sel_l    <= s1_l;
            sel_r    <= s1_r;
            s1_valid <= 1'b0;
            state    <= ST_SCAN;
          end else begin
            k <= k - ERR_W'(1);
          end
        end

        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            found_out <= hit;
            sel_p_out <= sel_p;
            sel_l_out <= sel_l;
            sel_r_out <= sel_r;
            state     <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/pds_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLL divider search checker
// Port-level checks of the divider search, bound to the top level.
// ----------------------------------------------------------------------------
module pds_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [pds_pkg::CLK_W-1:0]    pixel_clock_khz,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         found,
  input logic [pds_pkg::POST_W-1:0]   post_divider,
  input logic [pds_pkg::LOOP_W-1:0]   loop_multiplier,
  input logic [pds_pkg::REF_W-1:0]    ref_divider
);
  import pds_pkg::*;

  // A word that is not found carries all-zero settings.
  a_zero_when_missing: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |->
      (post_divider == '0 && loop_multiplier == '0 && ref_divider == '0))
    else $error("settings not zero for a word without a match");

  // A found setting is a legal one.
  a_legal_setting: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |->
      ((ref_divider == REF_W'(3) || ref_divider == REF_W'(4) ||
        ref_divider == REF_W'(5)) &&
       loop_multiplier >= loop_lo(ref_divider) &&
       loop_multiplier <= loop_hi(ref_divider)))
    else $error("reported divider setting out of range");

  // The block is busy right after it takes a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after a word");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(found) && $stable(post_divider) &&
       $stable(loop_multiplier) && $stable(ref_divider)))
    else $error("stalled result changed");

endmodule

bind pll_divider_search pds_checker u_pds_checker (.*);
